>>> rtl/krt_pkg.sv
// Shared constants, codes and types of the keyed record table.
package krt_pkg;

   // Table geometry and word widths.
   localparam int MaxEntries = 64;
   localparam int IdxW       = $clog2(MaxEntries);
   localparam int CntW       = $clog2(MaxEntries + 1);
   localparam int IdBits     = 64;
   localparam int PayBits    = 64;
   localparam int KeyBits    = 2 * IdBits;

   // Stream field widths.
   localparam int KindW      = 2;
   localparam int StatusW    = 3;
   localparam int SlotW      = 6;
   localparam int ReqDataW   = 2 * IdBits + PayBits;
   localparam int RspDataW   = ((SlotW + PayBits + 7) / 8) * 8;

   // Configuration port.
   localparam int CfgW       = 7;
   localparam int CsrAddrW   = 3;
   localparam int CsrDataW   = 32;
   localparam logic [CsrAddrW-3:0] RegEntriesInUse = '0;

   // Operation kinds.
   localparam logic [KindW-1:0] KindWrite  = 2'd0;
   localparam logic [KindW-1:0] KindRead   = 2'd1;
   localparam logic [KindW-1:0] KindDelete = 2'd2;

   // Result status codes.
   localparam logic [StatusW-1:0] StUpdated  = 3'd0;
   localparam logic [StatusW-1:0] StInserted = 3'd1;
   localparam logic [StatusW-1:0] StFull     = 3'd2;
   localparam logic [StatusW-1:0] StFound    = 3'd3;
   localparam logic [StatusW-1:0] StNotFound = 3'd4;
   localparam logic [StatusW-1:0] StDeleted  = 3'd5;

   typedef struct packed {
      logic [StatusW-1:0] status;
      logic [SlotW-1:0]   slot;
      logic [PayBits-1:0] read_payload;
   } result_type;

endpackage

>>> rtl/keyed_record_table_unit.sv
// Keyed record table: linear search over a table of (client id, server id) keyed records.
//
// The block keeps up to 64 records, each a pair of 64-bit ids plus one 64-bit payload word.
// Requests arrive on the req_ stream: tuser carries the operation kind (write, read,
// delete) and tdata carries client id, server id and payload. Every request transaction
// yields exactly one response transaction on the rsp_ stream: tuser carries the status
// and tdata carries the slot index and the read payload.
// The configuration register entries_in_use (byte address 0 of the csr_ port) limits the
// search to slots 0 .. entries_in_use-1; values above 64 act as 64.
// A request scans the table one entry per cycle through the read port of the key memory,
// stopping at the first valid matching key; the lowest free slot is noted along the way,
// so a write needs only one pass. A result goes from the compare stage into a result
// register and from there into the output register that drives the rsp_ stream; the
// block takes no request while it scans or holds a result. The response sits in an
// output register, so the next request is accepted while an earlier response still
// waits for rsp_tready; if that one is still stalled when the next result is ready,
// the block holds the new result until the output register frees up.
// Reset clears all valid marks at once, empties the output register and sets
// entries_in_use back to 64. The id and payload memories are not cleared: a slot is only
// read back after it has been written.
module keyed_record_table_unit (
   input  logic                              clock,
   input  logic                              reset,
   // Request stream.
   input  logic                              req_tvalid,
   output logic                              req_tready,
   // tdata fields, low bit up: client_id[63:0], server_id[127:64], payload[191:128].
   input  logic [krt_pkg::ReqDataW-1:0]      req_tdata,
   // tuser fields: kind[1:0].
   input  logic [krt_pkg::KindW-1:0]         req_tuser,
   // Response stream.
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   // tdata fields, low bit up: slot[5:0], read_payload[69:6], zero fill[71:70].
   output logic [krt_pkg::RspDataW-1:0]      rsp_tdata,
   // tuser fields: status[2:0].
   output logic [krt_pkg::StatusW-1:0]       rsp_tuser,
   // Configuration port.
   input  logic                              csr_psel,
   input  logic                              csr_penable,
   input  logic                              csr_pwrite,
   input  logic [krt_pkg::CsrAddrW-1:0]      csr_paddr,
   input  logic [krt_pkg::CsrDataW-1:0]      csr_pwdata,
   output logic [krt_pkg::CsrDataW-1:0]      csr_prdata,
   output logic                              csr_pready
);

   localparam logic [1:0] StIdle = 2'd0;
   localparam logic [1:0] StScan = 2'd1;
   localparam logic [1:0] StEmit = 2'd2;

   // Sequencer and configuration registers.
   logic [1:0]                     state_ff, state_in;
   logic [krt_pkg::CfgW-1:0]       entries_ff, entries_in;
   logic [krt_pkg::CntW-1:0]       limit_ff, limit_in;
   logic [krt_pkg::CntW-1:0]       scan_ff, scan_in;
   logic [krt_pkg::IdxW-1:0]       probe_ff, probe_in;
   logic                           probe_vld_ff, probe_vld_in;
   logic                           probe_last_ff, probe_last_in;
   logic [krt_pkg::IdxW-1:0]       free_ff, free_in;
   logic                           free_vld_ff, free_vld_in;
   logic [krt_pkg::MaxEntries-1:0] valid_ff, valid_in;

   // Latched request.
   logic [krt_pkg::KindW-1:0]      kind_ff, kind_in;
   logic [krt_pkg::KeyBits-1:0]    key_ff, key_in;
   logic [krt_pkg::PayBits-1:0]    pay_ff, pay_in;

   // Pending result and output register.
   krt_pkg::result_type            res_ff, res_in;
   krt_pkg::result_type            out_ff, out_in;
   logic                           out_vld_ff, out_vld_in;

   // Memories with registered read data.
   logic [krt_pkg::KeyBits-1:0]    key_mem [krt_pkg::MaxEntries];
   logic [krt_pkg::PayBits-1:0]    pay_mem [krt_pkg::MaxEntries];
   logic [krt_pkg::KeyBits-1:0]    key_q;
   logic [krt_pkg::PayBits-1:0]    pay_q;
   logic [krt_pkg::IdxW-1:0]       rd_addr;
   logic                           key_we, pay_we;
   logic [krt_pkg::IdxW-1:0]       key_wa, pay_wa;

   logic                           req_take;
   logic                           probe_hit;
   logic                           csr_write;
   logic [krt_pkg::IdxW-1:0]       scan_idx;

   assign req_tready = (state_ff == StIdle);
   assign req_take   = req_tvalid && req_tready;
   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign scan_idx   = scan_ff[krt_pkg::IdxW-1:0];
   assign rd_addr    = scan_idx;

   // A probe compares the entry whose key word came out of memory this cycle.
   assign probe_hit  = probe_vld_ff && valid_ff[probe_ff] && (key_q == key_ff);

   always_comb begin
      csr_prdata = '0;
      if (csr_paddr[krt_pkg::CsrAddrW-1:2] == krt_pkg::RegEntriesInUse) begin
         csr_prdata = {{(krt_pkg::CsrDataW - krt_pkg::CfgW){1'b0}}, entries_ff};
      end
   end

   assign rsp_tvalid = out_vld_ff;
   assign rsp_tuser  = out_ff.status;
   assign rsp_tdata  = {{(krt_pkg::RspDataW - krt_pkg::SlotW - krt_pkg::PayBits){1'b0}},
                        out_ff.read_payload, out_ff.slot};

   always_comb begin
      state_in      = state_ff;
      entries_in    = entries_ff;
      limit_in      = limit_ff;
      scan_in       = scan_ff;
      probe_in      = probe_ff;
      probe_vld_in  = probe_vld_ff;
      probe_last_in = probe_last_ff;
      free_in       = free_ff;
      free_vld_in   = free_vld_ff;
      valid_in      = valid_ff;
      kind_in       = kind_ff;
      key_in        = key_ff;
      pay_in        = pay_ff;
      res_in        = res_ff;
      out_in        = out_ff;
      out_vld_in    = out_vld_ff;
      key_we        = 1'b0;
      pay_we        = 1'b0;
      key_wa        = probe_ff;
      pay_wa        = probe_ff;

      if (csr_write && csr_paddr[krt_pkg::CsrAddrW-1:2] == krt_pkg::RegEntriesInUse) begin
         entries_in = csr_pwdata[krt_pkg::CfgW-1:0];
      end

      // The output register drains whenever the receiver takes the transaction.
      if (out_vld_ff && rsp_tready) begin
         out_vld_in = 1'b0;
      end

      case (state_ff)
         StIdle: begin
            if (req_take) begin
               kind_in      = req_tuser;
               key_in       = {req_tdata[2*krt_pkg::IdBits-1:krt_pkg::IdBits],
                               req_tdata[krt_pkg::IdBits-1:0]};
               pay_in       = req_tdata[krt_pkg::ReqDataW-1:2*krt_pkg::IdBits];
               // Slot counts past the table size saturate to the table size.
               if (int'(entries_ff) > krt_pkg::MaxEntries) begin
                  limit_in = krt_pkg::CntW'(krt_pkg::MaxEntries);
               end else begin
                  limit_in = krt_pkg::CntW'(entries_ff);
               end
               scan_in      = '0;
               probe_vld_in = 1'b0;
               free_vld_in  = 1'b0;
               state_in     = StScan;
            end
         end
         StScan: begin
            // Issue stage: read the next entry and note the lowest free slot.
            if (scan_ff < limit_ff) begin
               scan_in       = scan_ff + 1'b1;
               probe_in      = scan_idx;
               probe_vld_in  = 1'b1;
               probe_last_in = (scan_ff == limit_ff - 1'b1);
               if (!valid_ff[scan_idx] && !free_vld_ff) begin
                  free_vld_in = 1'b1;
                  free_in     = scan_idx;
               end
            end else begin
               probe_vld_in = 1'b0;
            end

            // Compare stage: a match ends the scan at once.
            if (probe_hit) begin
               res_in.status       = krt_pkg::StNotFound;
               res_in.slot         = krt_pkg::SlotW'(probe_ff);
               res_in.read_payload = '0;
               case (kind_ff)
                  krt_pkg::KindWrite: begin
                     pay_we        = 1'b1;
                     pay_wa        = probe_ff;
                     res_in.status = krt_pkg::StUpdated;
                  end
                  krt_pkg::KindRead: begin
                     res_in.status       = krt_pkg::StFound;
                     res_in.read_payload = pay_q;
                  end
                  krt_pkg::KindDelete: begin
                     valid_in[probe_ff] = 1'b0;
                     res_in.status      = krt_pkg::StDeleted;
                  end
                  default: begin
                     res_in.slot = '0;
                  end
               endcase
               state_in = StEmit;
            end else if ((probe_vld_ff && probe_last_ff) ||
                         (!probe_vld_ff && scan_ff >= limit_ff)) begin
               // Whole range searched without a match.
               res_in.status       = krt_pkg::StNotFound;
               res_in.slot         = '0;
               res_in.read_payload = '0;
               if (kind_ff == krt_pkg::KindWrite) begin
                  if (free_vld_ff) begin
                     key_we           = 1'b1;
                     key_wa           = free_ff;
                     pay_we           = 1'b1;
                     pay_wa           = free_ff;
                     valid_in[free_ff] = 1'b1;
                     res_in.status    = krt_pkg::StInserted;
                     res_in.slot      = krt_pkg::SlotW'(free_ff);
                  end else begin
                     res_in.status = krt_pkg::StFull;
                  end
               end
               state_in = StEmit;
            end
         end
         StEmit: begin
            if (!out_vld_ff || rsp_tready) begin
               out_in     = res_ff;
               out_vld_in = 1'b1;
               state_in   = StIdle;
            end
         end
         default: begin
            state_in = StIdle;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= StIdle;
         entries_ff   <= krt_pkg::CfgW'(krt_pkg::MaxEntries);
         valid_ff     <= '0;
         out_vld_ff   <= 1'b0;
         probe_vld_ff <= 1'b0;
         free_vld_ff  <= 1'b0;
         scan_ff      <= '0;
         limit_ff     <= '0;
      end else begin
         state_ff     <= state_in;
         entries_ff   <= entries_in;
         valid_ff     <= valid_in;
         out_vld_ff   <= out_vld_in;
         probe_vld_ff <= probe_vld_in;
         free_vld_ff  <= free_vld_in;
         scan_ff      <= scan_in;
         limit_ff     <= limit_in;
      end
   end

   always_ff @(posedge clock) begin
      probe_ff      <= probe_in;
      probe_last_ff <= probe_last_in;
      free_ff       <= free_in;
      kind_ff       <= kind_in;
      key_ff        <= key_in;
      pay_ff        <= pay_in;
      res_ff        <= res_in;
      out_ff        <= out_in;
   end

   // Key memory: client id in the low half, server id in the high half.
   always_ff @(posedge clock) begin
      if (key_we) begin
         key_mem[key_wa] <= key_ff;
      end
      key_q <= key_mem[rd_addr];
   end

   // Payload memory.
   always_ff @(posedge clock) begin
      if (pay_we) begin
         pay_mem[pay_wa] <= pay_ff;
      end
      pay_q <= pay_mem[rd_addr];
   end

endmodule

>>> verif/tb_keyed_record_table_unit.sv
`timescale 1ns / 1ps
// Self-checking testbench of the keyed record table: directed and random traffic with a shadow table.
import krt_pkg::*;

// Shadow copy of the record table. It works out the response of every accepted request
// and holds the responses that are still due, oldest first.
class record_table_shadow;
   logic                 occupied[MaxEntries];
   logic [IdBits-1:0]    client_word[MaxEntries];
   logic [IdBits-1:0]    server_word[MaxEntries];
   logic [PayBits-1:0]   payload_word[MaxEntries];
   logic [CfgW-1:0]      slot_limit;
   result_type           due_results[$];
   int unsigned          mismatches;

   function new();
      foreach (occupied[i]) begin
         occupied[i]     = 1'b0;
         client_word[i]  = '0;
         server_word[i]  = '0;
         payload_word[i] = '0;
      end
      slot_limit = CfgW'(MaxEntries);
      mismatches = 0;
   endfunction

   task report_mismatch(input string what);
      mismatches++;
      if (mismatches <= 40) $display("MISMATCH: %s", what);
   endtask

   // Applies one request to the shadow table and queues the response it must cause.
   function void accept_request(input logic [KindW-1:0] kind, input logic [IdBits-1:0] cid,
                                input logic [IdBits-1:0] sid, input logic [PayBits-1:0] pay);
      result_type outcome;
      int         searched;
      int         hit;
      bit         placed;
      searched = (slot_limit > MaxEntries) ? MaxEntries : int'(slot_limit);
      hit      = -1;
      placed   = 1'b0;
      for (int i = 0; i < searched; i++) begin
         if (hit < 0 && occupied[i] && client_word[i] == cid && server_word[i] == sid) hit = i;
      end
      outcome.status       = StNotFound;
      outcome.slot         = '0;
      outcome.read_payload = '0;
      case (kind)
         KindWrite: begin
            if (hit >= 0) begin
               payload_word[hit] = pay;
               outcome.status    = StUpdated;
               outcome.slot      = SlotW'(hit);
            end else begin
               // No live key: take the lowest free slot of the searched range.
               outcome.status = StFull;
               for (int i = 0; i < searched; i++) begin
                  if (!placed && !occupied[i]) begin
                     placed          = 1'b1;
                     occupied[i]     = 1'b1;
                     client_word[i]  = cid;
                     server_word[i]  = sid;
                     payload_word[i] = pay;
                     outcome.status  = StInserted;
                     outcome.slot    = SlotW'(i);
                  end
               end
            end
         end
         KindRead: begin
            if (hit >= 0) begin
               outcome.status       = StFound;
               outcome.slot         = SlotW'(hit);
               outcome.read_payload = payload_word[hit];
            end
         end
         KindDelete: begin
            if (hit >= 0) begin
               occupied[hit]  = 1'b0;
               outcome.status = StDeleted;
               outcome.slot   = SlotW'(hit);
            end
         end
         default: ;
      endcase
      due_results.push_back(outcome);
   endfunction

   // Compares one response transaction with the oldest response still due.
   task match_response(input logic [StatusW-1:0] status, input logic [SlotW-1:0] slot,
                       input logic [PayBits-1:0] read_payload);
      result_type want;
      if (due_results.size() == 0) begin
         report_mismatch($sformatf("response with none due: status %0d slot %0d", status, slot));
      end else begin
         want = due_results.pop_front();
         if (status !== want.status)
            report_mismatch($sformatf("status %0d, expected %0d", status, want.status));
         if (slot !== want.slot)
            report_mismatch($sformatf("slot %0d, expected %0d", slot, want.slot));
         if (read_payload !== want.read_payload)
            report_mismatch($sformatf("read payload %h, expected %h",
                                      read_payload, want.read_payload));
      end
   endtask

   task close_out();
      if (due_results.size() != 0)
         report_mismatch($sformatf("%0d responses never arrived", due_results.size()));
   endtask
endclass

module tb_keyed_record_table_unit;

   // The request kind that the block must treat as a no-op lookup.
   localparam logic [KindW-1:0]    KindUnused  = 2'd3;
   localparam logic [CsrAddrW-1:0] EntriesAddr = {RegEntriesInUse, 2'b00};
   localparam logic [63:0]         AllOnes     = '1;
   localparam logic [63:0]         Pat5        = 64'h5555_5555_5555_5555;
   localparam logic [63:0]         PatA        = 64'hAAAA_AAAA_AAAA_AAAA;
   localparam int                  CycleLimit  = 2_000_000;
   localparam int                  PhaseItems  = 150;
   localparam int                  PoolDepth   = 96;

   logic                   clock;
   logic                   reset;
   logic                   req_tvalid;
   logic                   req_tready;
   logic [ReqDataW-1:0]    req_tdata;
   logic [KindW-1:0]       req_tuser;
   logic                   rsp_tvalid;
   logic                   rsp_tready;
   logic [RspDataW-1:0]    rsp_tdata;
   logic [StatusW-1:0]     rsp_tuser;
   logic                   csr_psel;
   logic                   csr_penable;
   logic                   csr_pwrite;
   logic [CsrAddrW-1:0]    csr_paddr;
   logic [CsrDataW-1:0]    csr_pwdata;
   logic [CsrDataW-1:0]    csr_prdata;
   logic                   csr_pready;

   record_table_shadow     table_shadow;
   bit                     steady;        // when set, neither side inserts idle cycles
   int                     ready_left;
   int                     cycle_count;

   // Key pool for the random part: a few client words shared by many keys, so that
   // partial matches (same client, other server) happen often.
   logic [IdBits-1:0]      pool_cid[PoolDepth];
   logic [IdBits-1:0]      pool_sid[PoolDepth];

   keyed_record_table_unit i_dut (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tuser   (rsp_tuser),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   initial clock = 1'b0;
   always #6 clock = ~clock;

   // Idle lengths: mostly none or short, now and then a long one.
   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (steady) return 0;
      if (r < 55) return 0;
      if (r < 90) return $urandom_range(1, 3);
      if (r < 98) return $urandom_range(4, 12);
      return $urandom_range(20, 80);
   endfunction

   // Response side. Outputs are read in the active region right after the rising edge,
   // so they still hold the values that the edge sampled. rsp_tready gets stall runs of
   // random length between runs of readiness.
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready)
         table_shadow.match_response(rsp_tuser, rsp_tdata[SlotW-1:0],
                                     rsp_tdata[SlotW+PayBits-1:SlotW]);
      if (ready_left > 0) begin
         ready_left = ready_left - 1;
      end else if (rsp_tready) begin
         ready_left = pick_gap();
         if (ready_left > 0) rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= 1'b1;
         ready_left = $urandom_range(0, 10);
      end
   end

   // Watchdog: a hung handshake ends the run as a failure.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CycleLimit) begin
         $display("Timeout after %0d cycles", cycle_count);
         $display("*** FAILED ***");
         $finish;
      end
   end

   // Sends one request transaction after a random idle gap. tvalid is left high on
   // acceptance so that back-to-back requests need only one assignment per edge.
   task automatic send_request(input logic [KindW-1:0] kind, input logic [IdBits-1:0] cid,
                               input logic [IdBits-1:0] sid, input logic [PayBits-1:0] pay);
      int gap;
      gap = pick_gap();
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= kind;
      req_tdata  <= {pay, sid, cid};
      do @(posedge clock); while (!req_tready);
      table_shadow.accept_request(kind, cid, sid, pay);
   endtask

   // Stops sending and waits until every due response has come back.
   task automatic drain_table();
      req_tvalid <= 1'b0;
      while (table_shadow.due_results.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   // Writes entries_in_use through the csr_ port while the block is idle, then reads it
   // back. Upper data bits are sometimes set to show that only the low bits are kept.
   task automatic configure_slots(input int setting);
      logic [CsrDataW-1:0] wdata;
      logic [CsrDataW-1:0] readback;
      drain_table();
      wdata = CsrDataW'(setting);
      if ($urandom_range(0, 2) == 0) wdata = wdata | ($urandom & ~32'h7F);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= EntriesAddr;
      csr_pwdata  <= wdata;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      table_shadow.slot_limit = wdata[CfgW-1:0];
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      @(posedge clock);
      csr_psel    <= 1'b1;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      readback = csr_prdata;
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      if (readback !== {{(CsrDataW-CfgW){1'b0}}, wdata[CfgW-1:0]})
         table_shadow.report_mismatch($sformatf("entries_in_use reads %h after writing %h",
                                                readback, wdata));
   endtask

   initial begin
      int                phase_limit[11];
      int                pool_size;
      int                write_pct;
      int                r;
      int                pick;
      logic [KindW-1:0]  kind;
      logic [IdBits-1:0] cid;
      logic [IdBits-1:0] sid;
      logic [PayBits-1:0] pay;
      logic [IdBits-1:0] client_base[6];

      table_shadow = new();
      steady      = 1'b0;
      ready_left  = 0;
      cycle_count = 0;
      reset       = 1'b1;
      req_tvalid  = 1'b0;
      req_tdata   = '0;
      req_tuser   = KindWrite;
      rsp_tready  = 1'b0;
      csr_psel    = 1'b0;
      csr_penable = 1'b0;
      csr_pwrite  = 1'b0;
      csr_paddr   = '0;
      csr_pwdata  = '0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed part at the reset setting of 64 slots. Lookups in the empty table, the
      // unused kind, extreme ids and payloads, keys that share only one half, update,
      // delete and reuse of the freed slot.
      send_request(KindRead,   '0,      '0,      AllOnes);
      send_request(KindDelete, '0,      '0,      '0);
      send_request(KindUnused, '0,      '0,      AllOnes);
      send_request(KindWrite,  '0,      '0,      '0);
      send_request(KindWrite,  AllOnes, AllOnes, AllOnes);
      send_request(KindWrite,  '0,      AllOnes, Pat5);
      send_request(KindWrite,  AllOnes, '0,      PatA);
      send_request(KindRead,   AllOnes, AllOnes, '0);
      send_request(KindWrite,  '0,      '0,      AllOnes);
      send_request(KindUnused, '0,      '0,      '0);
      send_request(KindRead,   '0,      '0,      '0);
      send_request(KindDelete, '0,      AllOnes, '0);
      send_request(KindRead,   '0,      AllOnes, '0);
      send_request(KindDelete, '0,      AllOnes, '0);
      send_request(KindWrite,  Pat5,    PatA,    Pat5);

      // Two slots: a new key finds the table full and slot three drops out of sight.
      configure_slots(2);
      send_request(KindWrite,  PatA,    Pat5,    '0);
      send_request(KindRead,   AllOnes, '0,      '0);
      send_request(KindRead,   AllOnes, AllOnes, '0);

      // No slots at all: nothing is searched.
      configure_slots(0);
      send_request(KindWrite,  PatA,    PatA,    Pat5);
      send_request(KindRead,   '0,      '0,      '0);
      send_request(KindDelete, '0,      '0,      '0);

      // Counts above the table size behave as the full table.
      configure_slots(100);
      send_request(KindRead,   AllOnes, '0,      '0);
      configure_slots(127);
      send_request(KindRead,   Pat5,    PatA,    '0);

      // Random part: one phase per slot setting, each with its own key pool and mix.
      phase_limit = '{64, 5, 1, 64, 0, 100, 16, 127, 3, 64, 40};
      foreach (phase_limit[p]) begin
         configure_slots(phase_limit[p]);
         steady    = ($urandom_range(0, 3) == 0);
         write_pct = $urandom_range(35, 75);
         pool_size = (phase_limit[p] >= 64) ? $urandom_range(60, PoolDepth)
                                            : $urandom_range(2, 40);
         foreach (client_base[c]) client_base[c] = {$urandom, $urandom};
         for (int k = 0; k < pool_size; k++) begin
            pool_cid[k] = client_base[$urandom_range(0, 5)];
            pool_sid[k] = ($urandom_range(0, 3) == 0) ? client_base[$urandom_range(0, 5)]
                                                      : {$urandom, $urandom};
         end
         for (int n = 0; n < PhaseItems; n++) begin
            r    = $urandom_range(0, 99);
            pick = $urandom_range(0, pool_size - 1);
            cid  = pool_cid[pick];
            sid  = pool_sid[pick];
            pay  = {$urandom, $urandom};
            if ($urandom_range(0, 15) == 0) pay = ($urandom_range(0, 1) == 0) ? '0 : AllOnes;
            if (r < 3) begin
               kind = KindUnused;
            end else if (r < 8) begin
               // Noise: keys that are almost never in the table.
               kind = KindW'($urandom_range(0, 2));
               cid  = {$urandom, $urandom};
               sid  = {$urandom, $urandom};
            end else if ($urandom_range(0, 99) < write_pct) begin
               kind = KindWrite;
            end else begin
               kind = ($urandom_range(0, 9) < 6) ? KindRead : KindDelete;
            end
            send_request(kind, cid, sid, pay);
            // Now and then the sender holds off until the table has answered everything.
            if ($urandom_range(0, 199) == 0) drain_table();
         end
      end

      drain_table();
      repeat (80) @(posedge clock);
      table_shadow.close_out();
      if (table_shadow.mismatches == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

endmodule
